### rtl/page_run_first_fit_allocator_defines.svh
// Assertion macros for the page run allocator.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef PAGE_RUN_FIRST_FIT_ALLOCATOR_DEFINES_SVH
`define PAGE_RUN_FIRST_FIT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PRFFA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define PRFFA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/prffa_pkg.sv
// Shared types, constants and helpers for the page run allocator.
// No dependencies.
package prffa_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned TOTAL_PAGES_DEF = 16384;
  localparam int unsigned PAGE_BYTES_DEF  = 4096;

  // Port field widths
  localparam int unsigned SIZE_W     = 27;
  localparam int unsigned START_W    = 14;
  localparam int unsigned COUNT_W    = 15;
  localparam int unsigned PAGE_OUT_W = 14;

  // Map memory word: 32 pages per word
  localparam int unsigned WORD_W = 32;
  localparam int unsigned WBIT_W = $clog2(WORD_W);
  localparam logic [WBIT_W-1:0] TOP_BIT = WBIT_W'(WORD_W - 1);

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_ZERO    = 2'd2
  } status_e;

  // Command from the request decoder to the controller
  typedef struct packed {
    logic    go;
    logic    free;
    logic    quick;   // answered without touching the map
    status_e status;  // status of a quick answer
  } cmd_t;

  // Result strobe from the controller
  typedef struct packed {
    logic    done;
    status_e status;
  } res_t;

  // Index of the lowest set bit (0 when none)
  function automatic logic [WBIT_W-1:0] first_set(input logic [WORD_W-1:0] w);
    logic [WBIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) r = WBIT_W'(i);
    end
    return r;
  endfunction

endpackage

### rtl/prffa_map_ram.sv
// Page used map storage: one word of 32 page bits per entry.
// Synchronous, one write and one read port, registered read data. Uses prffa_pkg.
module prffa_map_ram #(
  parameter int unsigned DEPTH = prffa_pkg::TOTAL_PAGES_DEF / prffa_pkg::WORD_W,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [prffa_pkg::WORD_W-1:0]  wdata_i,
  input  logic                          re_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [prffa_pkg::WORD_W-1:0]  rdata_o
);

  logic [prffa_pkg::WORD_W-1:0] mem [0:DEPTH-1];
  logic [prffa_pkg::WORD_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/prffa_ctrl.sv
// Controller: clearing pass, first-fit scan and run mark/clear over the map.
// Uses prffa_pkg and prffa_map_ram.
module prffa_ctrl #(
  parameter int unsigned TOTAL_PAGES = prffa_pkg::TOTAL_PAGES_DEF,
  localparam int unsigned WORDS =
    (TOTAL_PAGES + prffa_pkg::WORD_W - 1) / prffa_pkg::WORD_W,
  localparam int unsigned WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1,
  localparam int unsigned PP_W  = WA_W + prffa_pkg::WBIT_W,
  localparam int unsigned PX_W  = PP_W + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  prffa_pkg::cmd_t   cmd_i,
  input  logic [PX_W-1:0]   pages_i,
  input  logic [PX_W-1:0]   lo_i,
  input  logic [PX_W-1:0]   hi_i,
  output logic              busy_o,
  output prffa_pkg::res_t   res_o,
  output logic [PX_W-1:0]   page_o
);

  localparam int unsigned BW    = prffa_pkg::WBIT_W;
  localparam logic [prffa_pkg::WORD_W-1:0] ALL1 = '1;

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_SCAN_RD  = 3'd2;
  localparam logic [2:0] S_SCAN_CHK = 3'd3;
  localparam logic [2:0] S_UPD_RD   = 3'd4;
  localparam logic [2:0] S_UPD_WR   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [WA_W-1:0]  clr_q, clr_d;
  logic             done_q, done_d;
  prffa_pkg::status_e status_q, status_d;
  logic [PX_W-1:0]  page_q, page_d;
  logic [PX_W-1:0]  b_q, b_d;     // candidate start / run low page
  logic [PX_W-1:0]  s_q, s_d;     // next page to test
  logic [PX_W-1:0]  e_q, e_d;     // last page of the run
  logic [PX_W-1:0]  lim_q, lim_d; // starts must stay below this
  logic [PX_W-1:0]  off_q, off_d; // pages + 1
  logic [WA_W-1:0]  u_q, u_d;     // word under update
  logic             set_q, set_d;

  // Memory port signals
  logic                         we, re;
  logic [WA_W-1:0]              waddr, raddr;
  logic [prffa_pkg::WORD_W-1:0] wdata, rdata;

  // Scan and update datapath
  logic [WA_W-1:0]              cw, ew, bw;
  logic                         e_same;
  logic [prffa_pkg::WORD_W-1:0] lo_mask, hi_mask, used, umask;
  logic [BW-1:0]                fs;
  logic [PX_W-1:0]              p, nb, ne;

  prffa_map_ram #(
    .DEPTH (WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Word-level view of the scan position and run bounds
  assign cw     = s_q[PP_W-1:BW];
  assign ew     = e_q[PP_W-1:BW];
  assign bw     = b_q[PP_W-1:BW];
  assign e_same = (ew == cw);

  // Pages of the current word that lie in the candidate run
  assign lo_mask = ALL1 << s_q[BW-1:0];
  assign hi_mask = e_same ? (ALL1 >> (prffa_pkg::TOP_BIT - e_q[BW-1:0])) : ALL1;
  assign used    = rdata & lo_mask & hi_mask;
  assign fs      = prffa_pkg::first_set(used);
  assign p       = PX_W'({cw, fs});
  assign nb      = p + PX_W'(2);
  assign ne      = p + off_q;

  // Bits of the word under update that belong to the run
  always_comb begin
    umask = ALL1;
    if (u_q == bw) umask = umask & (ALL1 << b_q[BW-1:0]);
    if (u_q == ew) umask = umask & (ALL1 >> (prffa_pkg::TOP_BIT - e_q[BW-1:0]));
  end

  // Memory port selection
  assign re    = (state_q == S_SCAN_RD) || (state_q == S_UPD_RD);
  assign raddr = (state_q == S_SCAN_RD) ? cw : u_q;
  assign we    = (state_q == S_CLEAR) || (state_q == S_UPD_WR);
  assign waddr = (state_q == S_CLEAR) ? clr_q : u_q;
  assign wdata = (state_q == S_CLEAR) ? '0 :
                 (set_q ? (rdata | umask) : (rdata & ~umask));

  // Next state and datapath updates
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    done_d   = 1'b0;
    status_d = status_q;
    page_d   = page_q;
    b_d      = b_q;
    s_d      = s_q;
    e_d      = e_q;
    lim_d    = lim_q;
    off_d    = off_q;
    u_d      = u_q;
    set_d    = set_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + WA_W'(1);
        if (clr_q == WA_W'(WORDS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_i.go) begin
          priority if (cmd_i.quick) begin
            done_d   = 1'b1;
            status_d = cmd_i.status;
            page_d   = '0;
          end else if (cmd_i.free) begin
            b_d     = lo_i;
            e_d     = hi_i;
            u_d     = lo_i[PP_W-1:BW];
            set_d   = 1'b0;
            state_d = S_UPD_RD;
          end else begin
            b_d     = '0;
            s_d     = '0;
            e_d     = pages_i - PX_W'(1);
            lim_d   = PX_W'(TOTAL_PAGES) - pages_i;
            off_d   = pages_i + PX_W'(1);
            set_d   = 1'b1;
            state_d = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (used != '0) begin
          // used page hit: resume two pages past it
          if (nb >= lim_q) begin
            done_d   = 1'b1;
            status_d = prffa_pkg::ST_NO_ROOM;
            page_d   = '0;
            state_d  = S_IDLE;
          end else begin
            b_d     = nb;
            s_d     = nb;
            e_d     = ne;
            state_d = (nb[PP_W-1:BW] == cw) ? S_SCAN_CHK : S_SCAN_RD;
          end
        end else if (e_same) begin
          // whole run free: go mark it
          u_d     = bw;
          state_d = S_UPD_RD;
        end else begin
          s_d     = PX_W'({cw, BW'(0)}) + PX_W'(prffa_pkg::WORD_W);
          state_d = S_SCAN_RD;
        end
      end
      S_UPD_RD: begin
        state_d = S_UPD_WR;
      end
      S_UPD_WR: begin
        if (u_q == ew) begin
          done_d   = 1'b1;
          status_d = prffa_pkg::ST_OK;
          page_d   = set_q ? b_q : '0;
          state_d  = S_IDLE;
        end else begin
          u_d     = u_q + WA_W'(1);
          state_d = S_UPD_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    page_q   <= page_d;
    b_q      <= b_d;
    s_q      <= s_d;
    e_q      <= e_d;
    lim_q    <= lim_d;
    off_q    <= off_d;
    u_q      <= u_d;
    set_q    <= set_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign res_o.done   = done_q;
  assign res_o.status = status_q;
  assign page_o       = page_q;

endmodule

### rtl/page_run_first_fit_allocator.sv
// Top level of the first-fit contiguous page allocator: request decode and ports.
// Uses prffa_pkg, prffa_ctrl and page_run_first_fit_allocator_defines.svh.
//
//  channel  | handshake                 | fields
//  ---------+---------------------------+---------------------------------------------
//  request  | start, busy (in at !busy) | operation_i, size_bytes_i, start_page_i,
//           |                           | page_count_i
//  result   | done_o (one-cycle strobe) | first_page_o, status_o
//
// Zero-size, oversize and empty-free requests answer in the next cycle.
// A free reads and writes back each map word (32 pages) that it touches.
// An allocate reads each map word it scans, checks an already-read word again
// after each used page hit inside it, then reads and writes back each word it
// marks; the map word memory has registered read data, so each write-back
// follows a read. After reset a clearing pass writes every map word
// (TOTAL_PAGES/32 rounded up, 512 at the default size) with busy high.
// Results cannot be stalled. PAGE_BYTES must be a power of two.
`include "page_run_first_fit_allocator_defines.svh"

module page_run_first_fit_allocator #(
  parameter int unsigned TOTAL_PAGES = prffa_pkg::TOTAL_PAGES_DEF,
  parameter int unsigned PAGE_BYTES  = prffa_pkg::PAGE_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              operation_i,
  input  logic [prffa_pkg::SIZE_W-1:0]      size_bytes_i,
  input  logic [prffa_pkg::START_W-1:0]     start_page_i,
  input  logic [prffa_pkg::COUNT_W-1:0]     page_count_i,
  output logic                              done_o,
  output logic [prffa_pkg::PAGE_OUT_W-1:0]  first_page_o,
  output logic [1:0]                        status_o
);

  localparam int unsigned WORDS = (TOTAL_PAGES + prffa_pkg::WORD_W - 1) / prffa_pkg::WORD_W;
  localparam int unsigned WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned PX_W  = WA_W + prffa_pkg::WBIT_W + 1;
  localparam int unsigned SZ_W  = prffa_pkg::SIZE_W + 1;
  localparam int unsigned PB_SH = $clog2(PAGE_BYTES);
  localparam int unsigned FW    = ((PX_W > prffa_pkg::COUNT_W) ? PX_W : prffa_pkg::COUNT_W) + 1;

  logic             accept;
  logic [SZ_W-1:0]  size_up, pages_full;
  logic             zero, too_big;
  logic [FW-1:0]    f_start, f_end, f_end_c;
  logic             f_empty;
  logic [PX_W-1:0]  pages, lo, hi, page;
  prffa_pkg::cmd_t  cmd;
  prffa_pkg::res_t  res;

  assign accept = start && !busy;

  // Allocate: round the byte size up to whole pages
  assign size_up    = SZ_W'(size_bytes_i) + SZ_W'(PAGE_BYTES - 1);
  assign pages_full = size_up >> PB_SH;
  assign zero       = (size_bytes_i == '0);
  assign too_big    = (pages_full >= SZ_W'(TOTAL_PAGES));
  assign pages      = PX_W'(pages_full);

  // Free: cut the run off at the end of the map
  assign f_start = FW'(start_page_i);
  assign f_end   = f_start + FW'(page_count_i);
  assign f_end_c = (f_end > FW'(TOTAL_PAGES)) ? FW'(TOTAL_PAGES) : f_end;
  assign f_empty = (f_start >= f_end_c);
  assign lo      = PX_W'(f_start);
  assign hi      = PX_W'(f_end_c - FW'(1));

  // Command to the controller
  always_comb begin
    cmd.go     = accept;
    cmd.free   = (operation_i == prffa_pkg::OP_FREE);
    cmd.quick  = 1'b0;
    cmd.status = prffa_pkg::ST_OK;
    if (operation_i == prffa_pkg::OP_FREE) begin
      cmd.quick = f_empty;
    end else if (zero) begin
      cmd.quick  = 1'b1;
      cmd.status = prffa_pkg::ST_ZERO;
    end else if (too_big) begin
      cmd.quick  = 1'b1;
      cmd.status = prffa_pkg::ST_NO_ROOM;
    end
  end

  prffa_ctrl #(
    .TOTAL_PAGES (TOTAL_PAGES)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .pages_i (pages),
    .lo_i    (lo),
    .hi_i    (hi),
    .busy_o  (busy),
    .res_o   (res),
    .page_o  (page)
  );

  assign done_o       = res.done;
  assign status_o     = res.status;
  assign first_page_o = page[prffa_pkg::PAGE_OUT_W-1:0];

  // Checks
  `PRFFA_ASSERT_NEXT(a_accept_tracked, start && !busy, done_o || busy, "accepted transaction lost")
  `PRFFA_ASSERT_NOW(a_done_has_cause, done_o, $past(busy) || $past(start && !busy), "spurious result")
  `PRFFA_ASSERT_NOW(a_fail_page_zero, done_o && (status_o != prffa_pkg::ST_OK), first_page_o == '0, "page on failure")

endmodule
